@@ hdl/jfp_pkg.sv @@
// shared constants, register codes and control types of the jacobi five-point sweep core
package jfp_pkg;

    localparam int MAX_COLS_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;

    localparam int GRID_COLS_W    = 11;
    localparam int STRIP_ROWS_W   = 13;
    localparam int ROW_W          = 13;
    localparam int ROWS_MAX       = 4096;
    localparam int MIN_COLS       = 3;
    localparam int FIRST_OUT_ROW  = 2;

    localparam int CFG_ADDR_W     = 4;
    localparam int CFG_DATA_W     = 32;

    localparam int GRID_COLS_RST  = 256;
    localparam int STRIP_ROWS_RST = 256;

    typedef enum logic [1:0] {
        REG_GRID_COLS    = 2'd0,
        REG_STRIP_ROWS   = 2'd1,
        REG_TOP_FIXED    = 2'd2,
        REG_BOTTOM_FIXED = 2'd3
    } jfp_reg_t;

    typedef enum logic [1:0] {
        FILL_A = 2'd0,
        FILL_B = 2'd1,
        RUN    = 2'd2
    } jfp_fill_t;

    typedef struct packed {
        logic [GRID_COLS_W-1:0]  grid_cols;
        logic [STRIP_ROWS_W-1:0] strip_rows;
        logic                    top_fixed;
        logic                    bottom_fixed;
    } jfp_cfg_t;

    typedef struct packed {
        logic copy;
        logic first;
        logic last;
    } jfp_flags_t;

endpackage

@@ hdl/jfp_ram.sv @@
// generic single write port, single read port ram with registered read data
module jfp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ hdl/jfp_cfg.sv @@
// apb configuration registers of the jacobi sweep core
module jfp_cfg import jfp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output jfp_cfg_t              cfg,
    output logic                  cols_written
);

    jfp_cfg_t cfg_reg;
    jfp_reg_t idx;
    logic     wr;

    assign idx          = jfp_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr           = psel && penable && pwrite;
    assign pready       = 1'b1;
    assign cfg          = cfg_reg;
    assign cols_written = wr && (idx == REG_GRID_COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_cols    <= GRID_COLS_W'(GRID_COLS_RST);
            cfg_reg.strip_rows   <= STRIP_ROWS_W'(STRIP_ROWS_RST);
            cfg_reg.top_fixed    <= 1'b1;
            cfg_reg.bottom_fixed <= 1'b1;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_GRID_COLS:    cfg_reg.grid_cols    <= pwdata[GRID_COLS_W-1:0];
                REG_STRIP_ROWS:   cfg_reg.strip_rows   <= pwdata[STRIP_ROWS_W-1:0];
                REG_TOP_FIXED:    cfg_reg.top_fixed    <= pwdata[0];
                REG_BOTTOM_FIXED: cfg_reg.bottom_fixed <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_GRID_COLS:    prdata = CFG_DATA_W'(cfg_reg.grid_cols);
            REG_STRIP_ROWS:   prdata = CFG_DATA_W'(cfg_reg.strip_rows);
            REG_TOP_FIXED:    prdata = CFG_DATA_W'(cfg_reg.top_fixed);
            REG_BOTTOM_FIXED: prdata = CFG_DATA_W'(cfg_reg.bottom_fixed);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ hdl/jfp_window.sv @@
// raster counters, line buffer ram, neighbour window and operand register
module jfp_window import jfp_pkg::*; #(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  jfp_cfg_t                     cfg,
    input  logic                         cols_written,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] cell_value,
    output logic                         op_valid,
    input  logic                         op_ready,
    output jfp_flags_t                   op_flags,
    output logic [VALUE_BITS-1:0]        op_up,
    output logic [VALUE_BITS-1:0]        op_center,
    output logic [VALUE_BITS-1:0]        op_left,
    output logic [VALUE_BITS-1:0]        op_right,
    output logic [VALUE_BITS-1:0]        op_down
);

    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int CAW    = $clog2(MAX_COLS);
    localparam int CMP_W  = (COLS_W > GRID_COLS_W) ? COLS_W : GRID_COLS_W;
    localparam int RMP_W  = STRIP_ROWS_W;

    jfp_fill_t state_reg, state_next;

    logic [CAW-1:0]   col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [VALUE_BITS-1:0] win_up_reg, win_ctr_reg, left_reg;

    logic                  op_valid_reg;
    jfp_flags_t            op_flags_reg;
    logic [VALUE_BITS-1:0] op_up_reg, op_center_reg, op_left_reg, op_right_reg, op_down_reg;

    logic [CMP_W-1:0]        gc;
    logic [COLS_W-1:0]       cols;
    logic [RMP_W-1:0]        rows;
    logic [ROW_W-1:0]        last_row;
    logic                    wrap;
    logic [CAW-1:0]          c;
    logic [COLS_W-1:0]       c_ext, c1;
    logic [COLS_W:0]         c2;
    logic [CAW-1:0]          next1, next2;
    logic [ROW_W-1:0]        r_inc, r, r1;
    logic                    c_last, row_end, produce, accept;
    jfp_flags_t              flags;

    logic                    re;
    logic [CAW-1:0]          raddr;
    logic [2*VALUE_BITS-1:0] rdata;
    logic [VALUE_BITS-1:0]   rd_above, rd_center;

    // effective geometry, clamped to the legal range
    always_comb
    begin
        gc = CMP_W'(cfg.grid_cols);
        if (gc < CMP_W'(MIN_COLS))
        begin
            cols = COLS_W'(MIN_COLS);
        end
        else if (gc > CMP_W'(MAX_COLS))
        begin
            cols = COLS_W'(MAX_COLS);
        end
        else
        begin
            cols = COLS_W'(gc);
        end

        if (cfg.strip_rows == '0)
        begin
            rows = RMP_W'(1);
        end
        else if (cfg.strip_rows > RMP_W'(ROWS_MAX))
        begin
            rows = RMP_W'(ROWS_MAX);
        end
        else
        begin
            rows = cfg.strip_rows;
        end
        last_row = ROW_W'(rows) + ROW_W'(1);
    end

    // position of the next beat, normalized against the current geometry
    always_comb
    begin
        wrap  = COLS_W'(col_reg) >= cols;
        c     = wrap ? '0 : col_reg;
        r_inc = wrap ? row_reg + ROW_W'(1) : row_reg;
        r     = (r_inc > last_row) ? '0 : r_inc;

        c_ext   = COLS_W'(c);
        c_last  = c_ext == (cols - COLS_W'(1));
        c1      = c_ext + COLS_W'(1);
        row_end = c1 >= cols;
        next1   = row_end ? '0 : c1[CAW-1:0];
        c2      = {1'b0, c_ext} + (COLS_W+1)'(2);
        next2   = (c2 >= {1'b0, cols}) ? CAW'(c2 - {1'b0, cols}) : c2[CAW-1:0];

        produce     = r >= ROW_W'(FIRST_OUT_ROW);
        flags.copy  = (c == '0) || c_last ||
                      (cfg.top_fixed && (r == ROW_W'(FIRST_OUT_ROW))) ||
                      (cfg.bottom_fixed && (r == last_row));
        flags.first = (r == ROW_W'(FIRST_OUT_ROW)) && (c == '0);
        flags.last  = (r == last_row) && c_last;

        r1 = r + ROW_W'(1);
        if (row_end)
        begin
            col_next = '0;
            row_next = (r1 > last_row) ? '0 : r1;
        end
        else
        begin
            col_next = c1[CAW-1:0];
            row_next = r;
        end
    end

    assign in_stall = (state_reg != RUN) || (op_valid_reg && !op_ready);
    assign accept   = in_valid && !in_stall;

    // window refill after reset or a change of row length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FILL_A;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        re         = 1'b0;
        raddr      = next2;
        unique case (state_reg)
            FILL_A:
            begin
                re         = 1'b1;
                raddr      = c;
                state_next = FILL_B;
            end
            FILL_B:
            begin
                re         = 1'b1;
                raddr      = next1;
                state_next = RUN;
            end
            RUN:
            begin
                re    = accept;
                raddr = next2;
            end
            default:
            begin
                state_next = FILL_A;
            end
        endcase
        if (cols_written)
        begin
            state_next = FILL_A;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            op_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            op_valid_reg <= produce;
        end
        else if (op_ready)
        begin
            op_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FILL_B)
        begin
            win_up_reg  <= rd_above;
            win_ctr_reg <= rd_center;
        end
        else if (accept)
        begin
            win_up_reg  <= rd_above;
            win_ctr_reg <= rd_center;
            left_reg    <= win_ctr_reg;
        end
        if (accept)
        begin
            op_flags_reg  <= flags;
            op_up_reg     <= win_up_reg;
            op_center_reg <= win_ctr_reg;
            op_left_reg   <= left_reg;
            op_right_reg  <= rd_center;
            op_down_reg   <= cell_value;
        end
    end

    // each word holds the row above in the high half and the center row in the low half
    jfp_ram #(
        .WIDTH (2*VALUE_BITS),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (c),
        .wdata ({win_ctr_reg, cell_value}),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_above  = rdata[2*VALUE_BITS-1:VALUE_BITS];
    assign rd_center = rdata[VALUE_BITS-1:0];

    assign op_valid  = op_valid_reg;
    assign op_flags  = op_flags_reg;
    assign op_up     = op_up_reg;
    assign op_center = op_center_reg;
    assign op_left   = op_left_reg;
    assign op_right  = op_right_reg;
    assign op_down   = op_down_reg;

    a_cols_refill: assert property (@(posedge clk) disable iff (!rst_n)
        cols_written |=> (state_reg == FILL_A))
        else $error("window refill not started after row length write");

    a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FILL_B) |=> (state_reg == RUN || state_reg == FILL_A))
        else $error("window refill sequence broken");

    a_op_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && produce) |=> op_valid_reg)
        else $error("operand register lost a result beat");

endmodule

@@ hdl/jfp_datapath.sv @@
// stencil average, change magnitude and running maximum with output register
module jfp_datapath import jfp_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         op_valid,
    output logic                         op_ready,
    input  jfp_flags_t                   op_flags,
    input  logic [VALUE_BITS-1:0]        op_up,
    input  logic [VALUE_BITS-1:0]        op_center,
    input  logic [VALUE_BITS-1:0]        op_left,
    input  logic [VALUE_BITS-1:0]        op_right,
    input  logic [VALUE_BITS-1:0]        op_down,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] new_value,
    output logic [VALUE_BITS-1:0]        delta_max,
    output logic                         sweep_done
);

    localparam int SW = VALUE_BITS + 2;

    logic                  s2_valid_reg, s3_valid_reg, out_valid_reg;
    jfp_flags_t            s2_flags_reg, s3_flags_reg;
    logic [VALUE_BITS-1:0] s2_nv_reg, s2_center_reg;
    logic [VALUE_BITS-1:0] s3_nv_reg, s3_mag_reg;
    logic [VALUE_BITS-1:0] new_value_reg, delta_max_reg;
    logic                  sweep_done_reg;

    logic                  s2_ready, s3_ready;
    logic                  s2_load, s3_load, out_load;
    logic [SW-1:0]         sum;
    logic [VALUE_BITS-1:0] avg;
    logic [VALUE_BITS:0]   d_fwd, d_rev;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base, max_next;

    assign s3_ready = !out_valid_reg || !out_stall;
    assign s2_ready = !s3_valid_reg || s3_ready;
    assign op_ready = !s2_valid_reg || s2_ready;
    assign s2_load  = op_valid && op_ready;
    assign s3_load  = s2_valid_reg && s2_ready;
    assign out_load = s3_valid_reg && s3_ready;

    // four-neighbour sum, arithmetic shift by two
    always_comb
    begin
        sum = {{2{op_up[VALUE_BITS-1]}}, op_up} + {{2{op_down[VALUE_BITS-1]}}, op_down} +
              {{2{op_left[VALUE_BITS-1]}}, op_left} +
              {{2{op_right[VALUE_BITS-1]}}, op_right};
        avg = op_flags.copy ? op_center : sum[SW-1:2];
    end

    // both differences in parallel, pick the non-negative one
    always_comb
    begin
        d_fwd = {s2_nv_reg[VALUE_BITS-1], s2_nv_reg} -
                {s2_center_reg[VALUE_BITS-1], s2_center_reg};
        d_rev = {s2_center_reg[VALUE_BITS-1], s2_center_reg} -
                {s2_nv_reg[VALUE_BITS-1], s2_nv_reg};
        mag   = d_fwd[VALUE_BITS] ? d_rev[VALUE_BITS-1:0] : d_fwd[VALUE_BITS-1:0];
    end

    // the first result of a sweep starts the maximum from zero
    always_comb
    begin
        base     = s3_flags_reg.first ? '0 : delta_max_reg;
        max_next = (!s3_flags_reg.copy && (s3_mag_reg > base)) ? s3_mag_reg : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            delta_max_reg <= '0;
        end
        else
        begin
            if (op_ready)
            begin
                s2_valid_reg <= op_valid;
            end
            if (s2_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (out_load)
            begin
                delta_max_reg <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_flags_reg  <= op_flags;
            s2_nv_reg     <= avg;
            s2_center_reg <= op_center;
        end
        if (s3_load)
        begin
            s3_flags_reg <= s2_flags_reg;
            s3_nv_reg    <= s2_nv_reg;
            s3_mag_reg   <= mag;
        end
        if (out_load)
        begin
            new_value_reg  <= s3_nv_reg;
            sweep_done_reg <= s3_flags_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_value  = new_value_reg;
    assign delta_max  = delta_max_reg;
    assign sweep_done = sweep_done_reg;

    a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !s3_flags_reg.first) |=> (delta_max_reg >= $past(delta_max_reg)))
        else $error("running maximum dropped inside a sweep");

    a_copy_keeps_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s3_flags_reg.copy && !s3_flags_reg.first) |=>
        (delta_max_reg == $past(delta_max_reg)))
        else $error("copied cell changed the running maximum");

    a_first_copy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s3_flags_reg.copy && s3_flags_reg.first) |=> (delta_max_reg == '0))
        else $error("running maximum not restarted at sweep start");

endmodule

@@ hdl/jacobi_five_point_sweep_core.sv @@
// top level of the streaming jacobi five-point sweep core
//
// input channel: one beat per grid cell (cell_value, signed q16.16) in raster
// order, grid_cols cells per row, strip_rows + 2 rows per sweep including the
// ghost rows above and below. accepted when in_valid is high and in_stall low
// output channel: one beat per cell of the row one behind the input, starting
// once the third row streams in; new_value, delta_max (running max of the
// absolute change this sweep) and sweep_done on the final cell of the sweep
// the result for cell (r-1, c) passes from the operand register through s2 and
// s3 to the output register; one beat per cycle while in_stall is low, set by
// the single write and single read port of the line buffer ram, one of each per cell
// reset and any write of grid_cols start a window refill from the line buffer,
// fill_a then fill_b, during which in_stall is high; no memory clearing pass
// a stalled output holds its beat; the three pipeline stages behind it keep
// filling, and in_stall rises once the operand register can not drain
// configuration over apb: grid_cols at 0x0, strip_rows at 0x4, top_fixed at
// 0x8, bottom_fixed at 0xc; write only while no beats are in flight
module jacobi_five_point_sweep_core import jfp_pkg::*; #(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // apb configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready,
    // cell stream in
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] cell_value,
    // result stream out
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] new_value,
    output logic [VALUE_BITS-1:0]        delta_max,
    output logic                         sweep_done
);

    jfp_cfg_t              cfg;
    logic                  cols_written;

    // operand handoff between the window and the arithmetic stages
    logic                  op_valid;
    logic                  op_ready;
    jfp_flags_t            op_flags;
    logic [VALUE_BITS-1:0] op_up, op_center, op_left, op_right, op_down;

    jfp_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cfg          (cfg),
        .cols_written (cols_written)
    );

    // line buffers, raster position and neighbour window
    jfp_window #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cols_written (cols_written),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cell_value   (cell_value),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op_flags     (op_flags),
        .op_up        (op_up),
        .op_center    (op_center),
        .op_left      (op_left),
        .op_right     (op_right),
        .op_down      (op_down)
    );

    // average, change magnitude, running maximum and output register
    jfp_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op_flags   (op_flags),
        .op_up      (op_up),
        .op_center  (op_center),
        .op_left    (op_left),
        .op_right   (op_right),
        .op_down    (op_down),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .new_value  (new_value),
        .delta_max  (delta_max),
        .sweep_done (sweep_done)
    );

endmodule
